// ===== hw/rtl/ddoi_pkg.sv =====
// ----------------------------------------------------------------------------
// ddoi_pkg: shared constants and types for the differential-drive odometry core
// Fixed-point formats, CORDIC arctangent table, sequencer states, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package ddoi_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int DIV_W        = 33 + FRAC_BITS;   // |r - l| << FRAC_BITS
    localparam int CNT_W        = 6;                // covers DIV_W and CORDIC_STEPS

    localparam logic [31:0] RIGHT_RST  = 32'd13107;  // 0.2 m/s
    localparam logic [31:0] LEFT_RST   = 32'd6554;   // 0.1 m/s
    localparam logic [31:0] SPACE_RST  = 32'd32768;  // 0.5 m
    localparam logic [29:0] RAD_TO_BAM = 30'd683565276;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    typedef enum logic [1:0] {
        REG_RIGHT = 2'd0,
        REG_LEFT  = 2'd1,
        REG_SPACE = 2'd2,
        REG_NONE  = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_ANG,
        S_CSET,
        S_CORD,
        S_CEND,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    // atan(2^-i) as a binary angle
    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;  default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/diff_drive_odometry_integrator_core.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator_core: dead-reckoning pose integrator
// Per tick: speeds from wheel config, CORDIC sin/cos, pose update, yaw quat.
// ----------------------------------------------------------------------------
//
//  channel   dir  bits  contents
//  s_axis    in    32   elapsed_time (Q16.16 s)
//  m_axis    out  224   pos_x, pos_y, heading_angle, quat_z, quat_w,
//                       linear_speed, angular_speed (32 bits each, low first)
//  i_cfg_*   in    32   register write: 0 right speed, 1 left speed, 2 spacing
//
//  From accept to the next ready, a word passes through 49 steps of the
//  bit-serial divide of the turn rate plus a state to saturate it, two
//  passes of 24 CORDIC steps (each with a load and a finish state), 7
//  multiply/consume pairs on one shared 34x34 multiplier, and a state to
//  load the output. Zero spacing skips the divide.
//  s_axis_tready is high only while the sequencer is idle. A finished word
//  sits in the output register; the next tick is taken meanwhile and the
//  sequencer holds in its last state until the output register frees up.
//  Synchronous active-low reset: pose zero, config regs to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_odometry_integrator_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // [31:0] elapsed_time
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [223:0]      m_axis_tdata,   // pos_x, pos_y, heading_angle, quat_z,
                                              // quat_w, linear_speed, angular_speed
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);

    localparam int F = ddoi_pkg::FRAC_BITS;
    localparam int W = ddoi_pkg::DIV_W;

    // config
    logic [31:0] r_right, r_left, r_space;
    // pose state
    logic [31:0] r_acc_x, r_acc_y, r_acc_h;

    ddoi_pkg::t_state r_state, n_state;
    logic [ddoi_pkg::CNT_W-1:0] r_cnt;
    logic [2:0]   r_mstep;
    logic         r_csel;          // 0: heading cos/sin, 1: half heading quat

    logic [31:0]  r_dt;
    logic signed [31:0] r_lin;
    logic signed [32:0] r_diff;
    logic signed [31:0] r_ang;
    logic [31:0]  r_rem;
    logic [W-1:0] r_quo;

    logic signed [33:0] r_cx, r_cy, r_cz;
    logic         r_flip;
    logic signed [31:0] r_cos, r_sin;
    logic signed [33:0] r_t;
    logic [63:0]  r_p, r_hlo;
    logic signed [67:0] r_prod;

    logic         r_ovalid;
    logic [223:0] r_odata;

    // ---------------- divide step ----------------
    logic [32:0] w_trial;
    logic        w_ge;
    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_ge    = w_trial >= {1'b0, r_space};

    // ---------------- CORDIC step ----------------
    logic [4:0] w_sh;
    logic signed [33:0] w_ys, w_xs, w_at;
    assign w_sh = r_cnt[4:0];
    assign w_ys = r_cy >>> w_sh;
    assign w_xs = r_cx >>> w_sh;
    assign w_at = $signed({2'b00, ddoi_pkg::atan_bam(w_sh)});

    logic [31:0] w_cang, w_fang;
    logic        w_cflip;
    assign w_cang  = r_csel ? {1'b0, r_acc_h[31:1]} : r_acc_h;
    assign w_cflip = w_cang[31] ^ w_cang[30];
    assign w_fang  = w_cflip ? (w_cang ^ 32'h80000000) : w_cang;

    function automatic logic signed [31:0] fin(input logic signed [33:0] v,
                                               input logic neg);
        logic signed [33:0] c;
        c = v;
        if (v > ddoi_pkg::ONE_Q30) c = ddoi_pkg::ONE_Q30;
        if (v < -ddoi_pkg::ONE_Q30) c = -ddoi_pkg::ONE_Q30;
        if (neg) c = -c;
        return c[31:0];
    endfunction

    logic signed [31:0] w_fx, w_fy;
    assign w_fx = fin(r_cx, r_flip);
    assign w_fy = fin(r_cy, r_flip);

    // ---------------- shared multiplier ----------------
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    always_comb begin
        w_ma = {{2{r_lin[31]}}, r_lin};
        w_mb = {{2{r_cos[31]}}, r_cos};
        case (r_mstep)
            3'd0: begin w_ma = {{2{r_lin[31]}}, r_lin}; w_mb = {{2{r_cos[31]}}, r_cos}; end
            3'd1: begin w_ma = r_t; w_mb = {2'b00, r_dt}; end
            3'd2: begin w_ma = {{2{r_lin[31]}}, r_lin}; w_mb = {{2{r_sin[31]}}, r_sin}; end
            3'd3: begin w_ma = r_t; w_mb = {2'b00, r_dt}; end
            3'd4: begin w_ma = {{2{r_ang[31]}}, r_ang}; w_mb = {2'b00, r_dt}; end
            3'd5: begin w_ma = {2'b00, r_p[31:0]}; w_mb = {4'b0, ddoi_pkg::RAD_TO_BAM}; end
            default: begin
                w_ma = {{2{r_p[63]}}, r_p[63:32]};
                w_mb = {4'b0, ddoi_pkg::RAD_TO_BAM};
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // position accumulate with saturation
    logic signed [67:0] w_d, w_accsel, w_sum;
    logic signed [31:0] w_sat;
    assign w_d      = r_prod >>> F;
    assign w_accsel = (r_mstep == 3'd1) ? {{36{r_acc_x[31]}}, r_acc_x}
                                        : {{36{r_acc_y[31]}}, r_acc_y};
    assign w_sum    = w_accsel + w_d;
    always_comb begin
        if (w_sum > 68'sd2147483647)       w_sat = 32'h7FFFFFFF;
        else if (w_sum < -68'sd2147483648) w_sat = 32'h80000000;
        else                               w_sat = w_sum[31:0];
    end

    // heading step: floor(p * K / 2^(2F)), low 32 bits
    logic signed [95:0] w_hsum, w_hstep;
    assign w_hsum  = $signed({r_prod[63:0], 32'b0}) + $signed({32'b0, r_hlo});
    assign w_hstep = w_hsum >>> (2 * F);

    // turn-rate saturation
    logic [32:0] w_qmag;
    logic signed [31:0] w_angv;
    always_comb begin
        w_qmag = (r_quo > {{(W-32){1'b0}}, 32'h80000000}) ? 33'h080000000 : r_quo[32:0];
        if (r_diff < 0)                     w_angv = 32'(-w_qmag);
        else if (w_qmag == 33'h080000000)   w_angv = 32'h7FFFFFFF;
        else                                w_angv = w_qmag[31:0];
    end

    // ---------------- sequencer ----------------
    logic w_acc_in;
    assign s_axis_tready = (r_state == ddoi_pkg::S_IDLE);
    assign w_acc_in      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddoi_pkg::S_IDLE: if (w_acc_in) begin
                n_state = (r_space == 32'd0) ? ddoi_pkg::S_CSET : ddoi_pkg::S_DIV;
            end
            ddoi_pkg::S_DIV: if (r_cnt == ddoi_pkg::CNT_W'(W - 1)) begin
                n_state = ddoi_pkg::S_ANG;
            end
            ddoi_pkg::S_ANG:  n_state = ddoi_pkg::S_CSET;
            ddoi_pkg::S_CSET: n_state = ddoi_pkg::S_CORD;
            ddoi_pkg::S_CORD: if (r_cnt == ddoi_pkg::CNT_W'(ddoi_pkg::CORDIC_STEPS - 1)) begin
                n_state = ddoi_pkg::S_CEND;
            end
            ddoi_pkg::S_CEND: n_state = r_csel ? ddoi_pkg::S_DONE : ddoi_pkg::S_MUL;
            ddoi_pkg::S_MUL:  n_state = ddoi_pkg::S_ACC;
            ddoi_pkg::S_ACC:  n_state = (r_mstep == 3'd6) ? ddoi_pkg::S_CSET : ddoi_pkg::S_MUL;
            ddoi_pkg::S_DONE: if (!r_ovalid || m_axis_tready) begin
                n_state = ddoi_pkg::S_IDLE;
            end
            default: n_state = ddoi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddoi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right  <= ddoi_pkg::RIGHT_RST;
            r_left   <= ddoi_pkg::LEFT_RST;
            r_space  <= ddoi_pkg::SPACE_RST;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r_acc_h  <= '0;
            r_cnt    <= '0;
            r_mstep  <= '0;
            r_csel   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (ddoi_pkg::t_reg_idx'(i_cfg_idx))
                    ddoi_pkg::REG_RIGHT: r_right <= i_cfg_data;
                    ddoi_pkg::REG_LEFT:  r_left  <= i_cfg_data;
                    ddoi_pkg::REG_SPACE: r_space <= i_cfg_data;
                    default: ;
                endcase
            end
            // output register: load wins over drain in the same cycle
            if (r_state == ddoi_pkg::S_DONE && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ddoi_pkg::S_IDLE: begin
                    r_cnt  <= '0;
                    r_csel <= 1'b0;
                end
                ddoi_pkg::S_DIV: r_cnt <= r_cnt + 1'b1;
                ddoi_pkg::S_CSET: r_cnt <= '0;
                ddoi_pkg::S_CORD: r_cnt <= r_cnt + 1'b1;
                ddoi_pkg::S_CEND: r_mstep <= '0;
                ddoi_pkg::S_ACC: begin
                    r_mstep <= r_mstep + 1'b1;
                    if (r_mstep == 3'd1) r_acc_x <= w_sat;
                    if (r_mstep == 3'd3) r_acc_y <= w_sat;
                    if (r_mstep == 3'd6) begin
                        r_acc_h <= r_acc_h + w_hstep[31:0];
                        r_csel  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    logic [32:0] w_rl;
    logic signed [32:0] w_diff;
    logic [32:0] w_absd;
    assign w_rl   = {r_right[31], r_right} + {r_left[31], r_left};
    assign w_diff = $signed({r_right[31], r_right}) - $signed({r_left[31], r_left});
    assign w_absd = w_diff[32] ? 33'(-w_diff) : w_diff;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ddoi_pkg::S_IDLE: if (w_acc_in) begin
                r_dt   <= s_axis_tdata;
                r_lin  <= w_rl[32:1];
                r_diff <= w_diff;
                r_rem  <= '0;
                // dividend |r - l| << F, shifted out msb first
                r_quo  <= {w_absd, {F{1'b0}}};
                if (r_space == 32'd0) begin
                    if ($signed(r_right) > $signed(r_left))      r_ang <= 32'h7FFFFFFF;
                    else if ($signed(r_right) < $signed(r_left)) r_ang <= 32'h80000000;
                    else                                         r_ang <= '0;
                end
            end
            ddoi_pkg::S_DIV: begin
                r_rem <= w_ge ? 32'(w_trial - {1'b0, r_space}) : w_trial[31:0];
                r_quo <= {r_quo[W-2:0], w_ge};
            end
            ddoi_pkg::S_ANG: r_ang <= w_angv;
            ddoi_pkg::S_CSET: begin
                r_cx   <= $signed(ddoi_pkg::CORDIC_GAIN);
                r_cy   <= '0;
                r_cz   <= {{2{w_fang[31]}}, w_fang};
                r_flip <= w_cflip;
            end
            ddoi_pkg::S_CORD: begin
                if (!r_cz[33]) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - w_at;
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + w_at;
                end
            end
            ddoi_pkg::S_CEND: begin
                r_cos <= w_fx;
                r_sin <= w_fy;
            end
            ddoi_pkg::S_MUL: r_prod <= w_prod;
            ddoi_pkg::S_ACC: begin
                if (r_mstep == 3'd0 || r_mstep == 3'd2) r_t <= 34'(r_prod >>> 30);
                if (r_mstep == 3'd4) r_p   <= r_prod[63:0];
                if (r_mstep == 3'd5) r_hlo <= r_prod[63:0];
            end
            ddoi_pkg::S_DONE: if (!r_ovalid || m_axis_tready) begin
                r_odata <= {r_ang, r_lin, r_cos, r_sin, r_acc_h, r_acc_y, r_acc_x};
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // ---------------- checks ----------------
    ap_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word taken while busy");
    ap_cordic_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ddoi_pkg::S_CORD) |-> (r_cnt < ddoi_pkg::CNT_W'(ddoi_pkg::CORDIC_STEPS)))
        else $error("CORDIC step counter overran");
    ap_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[159:128]) <= 32'sd1073741824
                        && $signed(m_axis_tdata[159:128]) >= -32'sd1073741824))
        else $error("quat_w outside unit range");
    ap_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ddoi_pkg::S_DONE && r_ovalid && !m_axis_tready)
        |=> (r_state == ddoi_pkg::S_DONE))
        else $error("result dropped while output held");

endmodule

`default_nettype wire
